[rtl/utf8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package utf8u16_pkg;

    // Width of the unit counter and of the max_units register.
    localparam int CNT_W = 10;

    localparam logic [CNT_W-1:0] MAX_UNITS_RESET = CNT_W'(63);

    localparam logic [15:0] REPL_CHAR    = 16'hFFFD;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // One input word.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in;

    // One result word.
    typedef struct packed {
        logic [15:0]      unit;
        logic             unit_valid;
        logic             end_of_text;
        logic [CNT_W-1:0] unit_count;
    } t_out;

endpackage

[rtl/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Payload
// input     in   i_in_valid / o_in_ready    i_in  (t_in: in_byte, last_byte)
// output    out  o_out_valid / i_out_ready  o_out (t_out: unit, unit_valid,
//                                                  end_of_text, unit_count)
// config    in   i_cfg_wr_en                i_cfg_wr_data (max_units)
//
// One input word per cycle while the output is ready; a word that yields two
// results (a surrogate pair, or a replacement plus the interrupting byte)
// holds the input while the two-entry result queue drains. i_rst_n is
// synchronous, active low: clears the stream state, empties the queue and
// loads max_units with 63. A stalled output holds the queued words and drops
// o_in_ready until the queue has room for two words.

module utf8_to_utf16_transcoder import utf8u16_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data
);

    logic [CNT_W-1:0] r_max_units;

    logic             accept;
    logic [1:0]       res_n;
    t_out             res0;
    t_out             res1;
    logic             room;

    // Unit limit register; the user must write it only between texts, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= MAX_UNITS_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_units <= i_cfg_wr_data;
        end
    end

    // Take a byte whenever the queue can absorb both possible results.
    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    // Decode the byte against the stream state and build up to two results.
    utf8u16_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_max_units (r_max_units),
        .o_res_n     (res_n),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    // Hold results until the consumer takes them, one word per cycle.
    utf8u16_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (accept ? res_n : 2'd0),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_head   (o_out),
        .o_room   (room)
    );

endmodule

[rtl/utf8u16_decode.sv]
// Byte decoder: stream state registers and the per-byte result logic.
`timescale 1ns / 1ps

module utf8u16_decode import utf8u16_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in              i_in,
    input  logic [CNT_W-1:0] i_max_units,
    output logic [1:0]       o_res_n,
    output t_out             o_res0,
    output t_out             o_res1
);

    typedef struct packed {
        logic [15:0]      u0;
        logic [15:0]      u1;
        logic [CNT_W-1:0] c0;
        logic [CNT_W-1:0] c1;
        logic [1:0]       n;
        logic [CNT_W-1:0] cnt;
        logic             full;
        logic [20:0]      pcp;
        logic [1:0]       bse;
    } t_acc;

    logic [20:0]      r_pcp;
    logic [1:0]       r_bse;
    logic [CNT_W-1:0] r_cnt;
    logic             r_full;

    t_acc             a;
    logic [20:0]      cp;

    function automatic t_acc f_push(t_acc x, logic [15:0] u);
        t_acc r;
        r = x;
        r.cnt = r.cnt + CNT_W'(1);
        if (r.n == 2'd0) begin
            r.u0 = u;
            r.c0 = r.cnt;
        end else begin
            r.u1 = u;
            r.c1 = r.cnt;
        end
        r.n = r.n + 2'd1;
        return r;
    endfunction

    // Emit one code point; a pair that does not fit is dropped and stops output.
    function automatic t_acc f_emit(t_acc x, logic [20:0] c, logic [CNT_W-1:0] lim);
        t_acc        r;
        logic [20:0] v;
        r = x;
        v = c - SUPP_BASE;
        if (c >= SUPP_BASE) begin
            if ({1'b0, x.cnt} + (CNT_W+1)'(2) > {1'b0, lim}) begin
                r.full = 1'b1;
            end else begin
                r = f_push(r, HI_SURR_BASE + 16'(v[20:10]));
                r = f_push(r, LO_SURR_BASE + 16'(v[9:0]));
            end
        end else begin
            r = f_push(r, c[15:0]);
        end
        if (r.cnt >= lim) begin
            r.full = 1'b1;
        end
        return r;
    endfunction

    // Handle a byte with no sequence open.
    function automatic t_acc f_fresh(t_acc x, logic [7:0] b, logic [CNT_W-1:0] lim);
        t_acc r;
        r = x;
        if (!b[7]) begin
            r = f_emit(r, 21'(b), lim);
        end else if (b[7:5] == 3'b110) begin
            r.pcp = 21'(b[4:0]);
            r.bse = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            r.pcp = 21'(b[3:0]);
            r.bse = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            r.pcp = 21'(b[2:0]);
            r.bse = 2'd3;
        end
        return r;
    endfunction

    always_comb begin
        a      = '0;
        a.cnt  = r_cnt;
        a.full = r_full;
        a.pcp  = r_pcp;
        a.bse  = r_bse;
        cp     = '0;
        if (a.cnt >= i_max_units) begin
            a.full = 1'b1;
        end
        if (!a.full) begin
            if (a.bse != 2'd0) begin
                if (i_in.in_byte[7:6] == 2'b10) begin
                    a.pcp = {a.pcp[14:0], i_in.in_byte[5:0]};
                    a.bse = a.bse - 2'd1;
                    if (a.bse == 2'd0) begin
                        cp    = a.pcp;
                        a.pcp = '0;
                        a     = f_emit(a, cp, i_max_units);
                    end
                end else begin
                    // Cut short: replacement, then take the byte afresh.
                    a.bse = 2'd0;
                    a.pcp = '0;
                    a     = f_emit(a, 21'(REPL_CHAR), i_max_units);
                    if (!a.full) begin
                        a = f_fresh(a, i_in.in_byte, i_max_units);
                    end
                end
            end else begin
                a = f_fresh(a, i_in.in_byte, i_max_units);
            end
        end
        if (i_in.last_byte) begin
            if (a.cnt >= i_max_units) begin
                a.full = 1'b1;
            end
            if (!a.full && a.bse != 2'd0) begin
                a = f_emit(a, 21'(REPL_CHAR), i_max_units);
            end
        end
    end

    always_comb begin
        o_res0.unit        = a.u0;
        o_res0.unit_valid  = (a.n != 2'd0);
        o_res0.end_of_text = i_in.last_byte && (a.n != 2'd2);
        o_res0.unit_count  = (a.n == 2'd0) ? a.cnt : a.c0;
        o_res1.unit        = a.u1;
        o_res1.unit_valid  = 1'b1;
        o_res1.end_of_text = i_in.last_byte;
        o_res1.unit_count  = a.c1;
        o_res_n            = (a.n == 2'd0 && i_in.last_byte) ? 2'd1 : a.n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcp  <= '0;
            r_bse  <= '0;
            r_cnt  <= '0;
            r_full <= 1'b0;
        end else if (i_accept) begin
            if (i_in.last_byte) begin
                r_pcp  <= '0;
                r_bse  <= '0;
                r_cnt  <= '0;
                r_full <= 1'b0;
            end else begin
                r_pcp  <= a.pcp;
                r_bse  <= a.bse;
                r_cnt  <= a.cnt;
                r_full <= a.full;
            end
        end
    end

endmodule

[rtl/utf8u16_outq.sv]
// Two-entry result queue: loads one or two words at once, drains one per cycle while the consumer is ready.
`timescale 1ns / 1ps

module utf8u16_outq import utf8u16_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_out       i_res0,
    input  t_out       i_res1,
    input  logic       i_ready,
    output logic       o_valid,
    output t_out       o_head,
    output logic       o_room
);

    t_out       r_q0;
    t_out       r_q1;
    logic [1:0] r_cnt;

    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q0;
    // Room for two new words once this cycle's pop is counted.
    assign o_room  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_push_n != 2'd0) begin
            r_cnt <= i_push_n;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_q0 <= i_res0;
            r_q1 <= i_res1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

endmodule
